@@ rtl/gtp_pkg.sv @@
// Shared types and codes for the two-pointer batch packer.
// No dependencies; used by gtp_ctrl, gtp_dp and the top level.
package gtp_pkg;

    // Configuration register indexes
    localparam logic CFG_CAPACITY  = 1'b0;
    localparam logic CFG_MAX_BATCH = 1'b1;

    // Width of each result field
    localparam int unsigned OUT_W = 5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH_I,
        ST_GET_I,
        ST_SCAN,
        ST_BATCH,
        ST_L_RD,
        ST_L_EV,
        ST_R_RD,
        ST_R_EV,
        ST_CLOSE,
        ST_FORCE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;        // accept one item
        logic sort_init;   // clear outer sort index
        logic fetch_i;     // read key of item i
        logic scan_start;  // latch key, start rank scan
        logic scan_step;   // compare one entry, write sorted entry at end
        logic pack_init;   // set pointers, clear batch number
        logic batch_init;  // clear sum and slot count
        logic rd_l;        // read sorted entry at left pointer
        logic rd_r;        // read sorted entry at right pointer
        logic place_l;     // place left entry into the batch
        logic place_r;     // place right entry into the batch
        logic close;       // emit held result as batch end
        logic force_one;   // place left entry alone
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;   // scan is at the final entry
        logic i_last;      // outer sort index at final item
        logic l_lt_r;      // unplaced entries remain
        logic one_left;    // exactly one unplaced entry
        logic cnt_ok;      // slot count below the batch limit
        logic cnt_zero;    // batch is still empty
        logic fits;        // read entry fits in remaining room
    } status_t;

endpackage

@@ rtl/greedy_two_pointer_batch_packer_core.sv @@
// Top level of the two-pointer greedy batch packer.
// Depends on gtp_pkg, gtp_ctrl and gtp_dp.
//
//  channel  | handshake           | beat
//  ---------+---------------------+----------------------------------------------
//  item in  | start && !busy      | token_count, item_last
//  result   | result_valid (1 cy) | item_index, batch_number, seq_slot,
//           |                     | batch_end, run_last
//  config   | cfg_valid&&cfg_ready| cfg_index, cfg_data
//
// Items load one per cycle while the block is not busy. After the last item a rank
// sort runs (one load-store read port, one compare per cycle), then packing
// forms batches from both ends of the sorted store; a batch that nothing
// fits is forced to hold a single item.
// Reset clears the sequencer, counters and config; stores need no clearing.
// Results cannot be stalled: each is shown for one cycle.
module greedy_two_pointer_batch_packer_core #(
    parameter int MAX_ITEMS = 32,
    parameter int LEN_BITS  = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [15:0]               token_count,
    input  logic                      item_last,
    output logic                      result_valid,
    output logic [gtp_pkg::OUT_W-1:0] item_index,
    output logic [gtp_pkg::OUT_W-1:0] batch_number,
    output logic [gtp_pkg::OUT_W-1:0] seq_slot,
    output logic                      batch_end,
    output logic                      run_last,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [15:0]               cfg_data
);

    gtp_pkg::cmd_t    cmd;
    gtp_pkg::status_t status;

    assign cfg_ready = 1'b1;

    gtp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item_last (item_last),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    gtp_dp #(
        .MAX_ITEMS (MAX_ITEMS),
        .LEN_BITS  (LEN_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .token_count  (token_count),
        .result_valid (result_valid),
        .item_index   (item_index),
        .batch_number (batch_number),
        .seq_slot     (seq_slot),
        .batch_end    (batch_end),
        .run_last     (run_last)
    );

    // No result in the cycle after an item beat
    a_no_result_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !result_valid)
        else $error("result right after item beat");

    // Run end always closes a batch
    a_run_last_ends_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && run_last) |-> batch_end)
        else $error("run end without batch end");

    // Sequencer is back to idle when the run's last result is out
    a_idle_at_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && run_last) |-> !busy)
        else $error("busy after run end");

endmodule

@@ rtl/gtp_ctrl.sv @@
// Sequencer for load, rank sort and two-pointer packing.
// Depends on gtp_pkg; drives gtp_dp through cmd_t, reads status_t.
module gtp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             item_last,
    input  gtp_pkg::status_t status,
    output gtp_pkg::cmd_t    cmd,
    output logic             busy
);

    gtp_pkg::state_t state_reg;
    gtp_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gtp_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            gtp_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (item_last)
                    begin
                        cmd.sort_init = 1'b1;
                        state_next    = gtp_pkg::ST_FETCH_I;
                    end
                end
            end
            gtp_pkg::ST_FETCH_I:
            begin
                cmd.fetch_i = 1'b1;
                state_next  = gtp_pkg::ST_GET_I;
            end
            gtp_pkg::ST_GET_I:
            begin
                cmd.scan_start = 1'b1;
                state_next     = gtp_pkg::ST_SCAN;
            end
            gtp_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    if (status.i_last)
                    begin
                        cmd.pack_init = 1'b1;
                        state_next    = gtp_pkg::ST_BATCH;
                    end
                    else
                        state_next = gtp_pkg::ST_FETCH_I;
                end
            end
            gtp_pkg::ST_BATCH:
            begin
                cmd.batch_init = 1'b1;
                state_next     = gtp_pkg::ST_L_RD;
            end
            gtp_pkg::ST_L_RD:
            begin
                if (status.l_lt_r && status.cnt_ok)
                begin
                    cmd.rd_l   = 1'b1;
                    state_next = gtp_pkg::ST_L_EV;
                end
                else
                    state_next = gtp_pkg::ST_CLOSE;
            end
            gtp_pkg::ST_L_EV:
            begin
                if (status.fits)
                begin
                    cmd.place_l = 1'b1;
                    state_next  = gtp_pkg::ST_R_RD;
                end
                else
                    state_next = gtp_pkg::ST_CLOSE;
            end
            gtp_pkg::ST_R_RD:
            begin
                if (status.l_lt_r && status.cnt_ok)
                begin
                    cmd.rd_r   = 1'b1;
                    state_next = gtp_pkg::ST_R_EV;
                end
                else
                    state_next = gtp_pkg::ST_L_RD;
            end
            gtp_pkg::ST_R_EV:
            begin
                if (status.fits)
                begin
                    cmd.place_r = 1'b1;
                    state_next  = gtp_pkg::ST_R_RD;
                end
                else
                    state_next = gtp_pkg::ST_L_RD;
            end
            gtp_pkg::ST_CLOSE:
            begin
                if (status.cnt_zero)
                begin
                    // empty batch: take the longest entry alone
                    cmd.rd_l   = 1'b1;
                    state_next = gtp_pkg::ST_FORCE;
                end
                else
                begin
                    cmd.close  = 1'b1;
                    state_next = status.l_lt_r ? gtp_pkg::ST_BATCH : gtp_pkg::ST_IDLE;
                end
            end
            gtp_pkg::ST_FORCE:
            begin
                cmd.force_one = 1'b1;
                state_next    = status.one_left ? gtp_pkg::ST_IDLE : gtp_pkg::ST_BATCH;
            end
            default:
                state_next = gtp_pkg::ST_IDLE;
        endcase
    end

endmodule

@@ rtl/gtp_dp.sv @@
// Datapath: config registers, load store, rank sort, sorted store, pack pointers.
// Depends on gtp_pkg; commanded by gtp_ctrl.
module gtp_dp #(
    parameter int MAX_ITEMS = 32,
    parameter int LEN_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gtp_pkg::cmd_t                cmd,
    output gtp_pkg::status_t             status,
    input  logic                         cfg_valid,
    input  logic                         cfg_index,
    input  logic [15:0]                  cfg_data,
    input  logic [15:0]                  token_count,
    output logic                         result_valid,
    output logic [gtp_pkg::OUT_W-1:0]    item_index,
    output logic [gtp_pkg::OUT_W-1:0]    batch_number,
    output logic [gtp_pkg::OUT_W-1:0]    seq_slot,
    output logic                         batch_end,
    output logic                         run_last
);

    localparam int IDXW = $clog2(MAX_ITEMS);
    localparam int CNTW = IDXW + 1;
    localparam int CW   = (CNTW > 6) ? CNTW : 6;
    localparam int SW   = ((LEN_BITS > 16) ? LEN_BITS : 16) + 1;
    localparam logic [SW-1:0]   LEN_MAX = SW'((64'd1 << LEN_BITS) - 64'd1);
    localparam logic [CNTW-1:0] FULL    = CNTW'(MAX_ITEMS);

    // Configuration
    logic [15:0] cap_reg;
    logic [5:0]  maxb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= 16'd512;
            maxb_reg <= 6'd16;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gtp_pkg::CFG_CAPACITY:  cap_reg  <= cfg_data;
                gtp_pkg::CFG_MAX_BATCH: maxb_reg <= cfg_data[5:0];
                default:                cap_reg  <= cap_reg;
            endcase
        end
    end

    // Control counters and pointers
    logic [CNTW-1:0] count_reg;
    logic [IDXW-1:0] i_reg;
    logic [IDXW-1:0] jd_reg;
    logic [IDXW-1:0] rank_reg;
    logic [CNTW-1:0] l_reg;
    logic [CNTW-1:0] rp_reg;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   batch_reg;
    logic            pend_reg;

    // Payload registers
    logic [LEN_BITS-1:0] key_reg;
    logic [SW-1:0]       sum_reg;
    logic [IDXW-1:0]     pend_org_reg;
    logic [CW-1:0]       pend_slot_reg;

    // Memories
    logic [LEN_BITS-1:0] len_mem [MAX_ITEMS];
    logic [LEN_BITS-1:0] a_rd_reg;
    logic [LEN_BITS-1:0] slen_mem [MAX_ITEMS];
    logic [IDXW-1:0]     sorg_mem [MAX_ITEMS];
    logic [LEN_BITS-1:0] b_len_reg;
    logic [IDXW-1:0]     b_org_reg;

    // Saturate incoming length to capacity and storage width
    logic [SW-1:0]       sat_cap;
    logic [LEN_BITS-1:0] len_in;
    assign sat_cap = (token_count > cap_reg) ? SW'(cap_reg) : SW'(token_count);
    assign len_in  = (sat_cap > LEN_MAX) ? LEN_MAX[LEN_BITS-1:0] : sat_cap[LEN_BITS-1:0];

    // Rank compare: entry jd goes ahead of item i
    logic            ahead;
    logic [IDXW-1:0] rank_now;
    logic [IDXW-1:0] a_addr;
    logic [IDXW-1:0] b_addr;
    logic [CNTW-1:0] rp_dec;
    assign ahead    = (a_rd_reg > key_reg) || ((a_rd_reg == key_reg) && (jd_reg < i_reg));
    assign rank_now = rank_reg + IDXW'(ahead);
    assign a_addr   = cmd.fetch_i ? i_reg : (cmd.scan_start ? '0 : IDXW'(jd_reg + 1'b1));
    assign rp_dec   = rp_reg - 1'b1;
    assign b_addr   = cmd.rd_r ? rp_dec[IDXW-1:0] : l_reg[IDXW-1:0];

    // Status
    logic [SW-1:0] sum_try;
    assign sum_try          = sum_reg + SW'(b_len_reg);
    assign status.scan_last = ((CNTW'(jd_reg) + 1'b1) == count_reg);
    assign status.i_last    = ((CNTW'(i_reg) + 1'b1) == count_reg);
    assign status.l_lt_r    = (l_reg < rp_reg);
    assign status.one_left  = ((l_reg + 1'b1) == rp_reg);
    assign status.cnt_ok    = (cnt_reg < CW'(maxb_reg));
    assign status.cnt_zero  = (cnt_reg == '0);
    assign status.fits      = (sum_try <= SW'(cap_reg));

    // Load store: write on load, one read port for the sort scan
    always_ff @(posedge clk)
    begin
        if (cmd.load && (count_reg < FULL))
            len_mem[count_reg[IDXW-1:0]] <= len_in;
        a_rd_reg <= len_mem[a_addr];
    end

    // Sorted store: written at the rank, read at one pointer
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && status.scan_last)
        begin
            slen_mem[rank_now] <= key_reg;
            sorg_mem[rank_now] <= i_reg;
        end
        if (cmd.rd_l || cmd.rd_r)
        begin
            b_len_reg <= slen_mem[b_addr];
            b_org_reg <= sorg_mem[b_addr];
        end
    end

    // Control state
    logic placing;
    logic finishing;
    assign placing   = cmd.place_l || cmd.place_r;
    assign finishing = (cmd.close && !status.l_lt_r) || (cmd.force_one && status.one_left);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            i_reg        <= '0;
            jd_reg       <= '0;
            rank_reg     <= '0;
            l_reg        <= '0;
            rp_reg       <= '0;
            cnt_reg      <= '0;
            batch_reg    <= '0;
            pend_reg     <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= placing && pend_reg || cmd.close || cmd.force_one;
            if (cmd.load && (count_reg < FULL))
                count_reg <= count_reg + 1'b1;
            if (finishing)
                count_reg <= '0;
            if (cmd.sort_init)
                i_reg <= '0;
            if (cmd.scan_start)
            begin
                jd_reg   <= '0;
                rank_reg <= '0;
            end
            if (cmd.scan_step)
            begin
                jd_reg   <= jd_reg + 1'b1;
                rank_reg <= rank_now;
                if (status.scan_last)
                    i_reg <= i_reg + 1'b1;
            end
            if (cmd.pack_init)
            begin
                l_reg     <= '0;
                rp_reg    <= count_reg;
                batch_reg <= '0;
                pend_reg  <= 1'b0;
            end
            if (cmd.batch_init)
                cnt_reg <= '0;
            if (placing)
            begin
                cnt_reg  <= cnt_reg + 1'b1;
                pend_reg <= 1'b1;
            end
            if (cmd.place_l || cmd.force_one)
                l_reg <= l_reg + 1'b1;
            if (cmd.place_r)
                rp_reg <= rp_dec;
            if (cmd.close || cmd.force_one)
            begin
                batch_reg <= batch_reg + 1'b1;
                pend_reg  <= 1'b0;
            end
        end
    end

    // Payload: key, running sum, held result, result ports
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
            key_reg <= a_rd_reg;
        if (cmd.batch_init)
            sum_reg <= '0;
        if (placing)
        begin
            sum_reg       <= sum_try;
            pend_org_reg  <= b_org_reg;
            pend_slot_reg <= cnt_reg;
        end
        if (placing || cmd.close)
        begin
            // held result goes out once its successor or the batch end is known
            item_index   <= gtp_pkg::OUT_W'(pend_org_reg);
            batch_number <= gtp_pkg::OUT_W'(batch_reg);
            seq_slot     <= gtp_pkg::OUT_W'(pend_slot_reg);
            batch_end    <= cmd.close;
            run_last     <= cmd.close && !status.l_lt_r;
        end
        if (cmd.force_one)
        begin
            item_index   <= gtp_pkg::OUT_W'(b_org_reg);
            batch_number <= gtp_pkg::OUT_W'(batch_reg);
            seq_slot     <= '0;
            batch_end    <= 1'b1;
            run_last     <= status.one_left;
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for greedy_two_pointer_batch_packer_core.
// Depends on gtp_pkg and the core RTL; packing is predicted in a small scoreboard class.
module testbench;

    typedef struct {
        logic [4:0] idx;
        logic [4:0] bnum;
        logic [4:0] slot;
        logic       bend;
        logic       rlast;
    } placement_t;

    // Predicts the batch placements of each set and checks the results against them
    class packing_board;
        logic [15:0] cap;
        logic [5:0]  max_batch;
        logic [15:0] len_q [32];
        int unsigned org_q [32];
        bit          placed [32];
        int unsigned loaded;
        placement_t  staged [$];
        placement_t  placements [$];
        int unsigned errors;

        function new();
            cap = 16'd512;
            max_batch = 6'd16;
            loaded = 0;
            errors = 0;
            foreach (placed[i]) placed[i] = 0;
        endfunction

        function void write_reg(logic index, logic [15:0] data);
            if (index == gtp_pkg::CFG_CAPACITY) cap = data;
            else max_batch = data[5:0];
        endfunction

        function void place(int n, int unsigned bnum, int unsigned slot);
            placement_t p;
            placed[n] = 1;
            p.idx = org_q[n][4:0];
            p.bnum = bnum[4:0];
            p.slot = slot[4:0];
            p.bend = 0;
            p.rlast = 0;
            staged = {staged, p};
        endfunction

        // Sort the stored set, then form batches two-pointer style
        function void pack_set();
            int total, done, lft, rgt, i, j;
            int unsigned cnt, sum, bnum, ol;
            logic [15:0] l;
            placement_t p;
            total = loaded;
            done = 0;
            bnum = 0;
            for (i = 1; i < total; i++) begin
                l = len_q[i];
                ol = org_q[i];
                j = i - 1;
                while (j >= 0 && (len_q[j] < l || (len_q[j] == l && org_q[j] > ol))) begin
                    len_q[j+1] = len_q[j];
                    org_q[j+1] = org_q[j];
                    j--;
                end
                len_q[j+1] = l;
                org_q[j+1] = ol;
            end
            while (done < total) begin
                lft = -1;
                for (i = 0; i < total; i++)
                    if (!placed[i]) begin
                        lft = i;
                        break;
                    end
                if (lft < 0) break;
                rgt = total - 1;
                while (rgt >= lft && placed[rgt]) rgt--;
                cnt = 0;
                sum = 0;
                while (lft <= rgt && cnt < max_batch) begin
                    if (sum + len_q[lft] > cap) break;
                    sum += len_q[lft];
                    place(lft, bnum, cnt);
                    done++;
                    cnt++;
                    lft++;
                    while (lft <= rgt && placed[lft]) lft++;
                    while (rgt >= lft && cnt < max_batch && !placed[rgt]) begin
                        if (sum + len_q[rgt] > cap) break;
                        sum += len_q[rgt];
                        place(rgt, bnum, cnt);
                        done++;
                        cnt++;
                        rgt--;
                        while (rgt >= lft && placed[rgt]) rgt--;
                    end
                end
                // empty batch (nothing fits or the batch limit is zero): the first unplaced entry goes alone
                if (cnt == 0) begin
                    for (i = 0; i < total; i++)
                        if (!placed[i]) begin
                            place(i, bnum, cnt);
                            done++;
                            cnt++;
                            break;
                        end
                    if (cnt == 0) break;
                end
                p = staged.pop_back();
                p.bend = 1;
                staged = {staged, p};
                bnum++;
            end
            if (staged.size() > 0) begin
                p = staged.pop_back();
                p.rlast = 1;
                staged = {staged, p};
            end
            while (staged.size() > 0) begin
                p = staged.pop_front();
                placements = {placements, p};
            end
            foreach (placed[k]) placed[k] = 0;
            loaded = 0;
        endfunction

        // Note one accepted item beat
        function void note_item(logic [15:0] tokens, logic last);
            if (loaded < 32) begin
                len_q[loaded] = (tokens > cap) ? cap : tokens;
                org_q[loaded] = loaded;
                loaded++;
            end
            if (last) pack_set();
        endfunction

        function void check_result(logic [4:0] idx, logic [4:0] bnum, logic [4:0] slot,
                                   logic bend, logic rlast);
            placement_t p;
            if (placements.size() == 0) begin
                $display("%0t: unexpected result idx=%0d batch=%0d slot=%0d",
                         $time, idx, bnum, slot);
                errors++;
                return;
            end
            p = placements.pop_front();
            if (p.idx !== idx) begin
                $display("%0t: item_index expected %0d actual %0d", $time, p.idx, idx);
                errors++;
            end
            if (p.bnum !== bnum) begin
                $display("%0t: batch_number expected %0d actual %0d", $time, p.bnum, bnum);
                errors++;
            end
            if (p.slot !== slot) begin
                $display("%0t: seq_slot expected %0d actual %0d", $time, p.slot, slot);
                errors++;
            end
            if (p.bend !== bend) begin
                $display("%0t: batch_end expected %0d actual %0d", $time, p.bend, bend);
                errors++;
            end
            if (p.rlast !== rlast) begin
                $display("%0t: run_last expected %0d actual %0d", $time, p.rlast, rlast);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] token_count;
    logic        item_last;
    logic        result_valid;
    logic [4:0]  item_index;
    logic [4:0]  batch_number;
    logic [4:0]  seq_slot;
    logic        batch_end;
    logic        run_last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    packing_board board;
    bit           no_idle;
    int unsigned  stall_cycles;
    int unsigned  sent;

    greedy_two_pointer_batch_packer_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .token_count(token_count), .item_last(item_last),
        .result_valid(result_valid), .item_index(item_index),
        .batch_number(batch_number), .seq_slot(seq_slot),
        .batch_end(batch_end), .run_last(run_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Result monitor and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (result_valid)
                board.check_result(item_index, batch_number, seq_slot, batch_end, run_last);
            if (result_valid || (start && !busy) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= 20000) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic int unsigned pick_gap();
        if (no_idle || $urandom_range(99) >= 37) return 0;
        return $urandom_range(1, 6);
    endfunction

    // Drive one item beat and wait for it to be taken
    task automatic send_item(logic [15:0] tokens, logic last);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        token_count <= tokens;
        item_last <= last;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_item(tokens, last);
        sent++;
    endtask

    // Register write once the block has drained
    task automatic write_reg(logic index, logic [15:0] data);
        start <= 1'b0;
        while (board.placements.size() > 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.write_reg(index, data);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_tokens(logic [15:0] cap);
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return (cap == 0) ? 16'(0) : 16'($urandom_range(0, cap));
        endcase
    endfunction

    function automatic logic [15:0] pick_cap();
        case ($urandom_range(7))
            0: return 16'd1;
            1: return 16'hFFFF;
            2: return 16'd0;
            3: return 16'($urandom);
            default: return 16'($urandom_range(1, 400));
        endcase
    endfunction

    function automatic logic [15:0] pick_max();
        case ($urandom_range(5))
            0: return 16'd1;
            1: return 16'd32;
            2: return {10'($urandom_range(0, 1023)), 6'd0};
            3: return 16'($urandom);
            default: return 16'($urandom_range(1, 8));
        endcase
    endfunction

    // Stimulus
    initial
    begin
        int unsigned n, lim;
        board = new();
        start = 0;
        token_count = 0;
        item_last = 0;
        cfg_valid = 0;
        cfg_index = gtp_pkg::CFG_CAPACITY;
        cfg_data = 0;
        no_idle = 0;
        stall_cycles = 0;
        sent = 0;
        rst_n = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: field extremes and a single-item set
        send_item(16'd0, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'd100, 1'b0);
        send_item(16'd412, 1'b1);
        send_item(16'd7, 1'b1);

        // capacity of zero: every length saturates and fits
        write_reg(gtp_pkg::CFG_CAPACITY, 16'd0);
        write_reg(gtp_pkg::CFG_MAX_BATCH, 16'd3);
        for (int i = 0; i < 5; i++) send_item(16'(16'hFFFF - i), i == 4);

        // max batch of zero forces single-item batches
        write_reg(gtp_pkg::CFG_CAPACITY, 16'hFFFF);
        write_reg(gtp_pkg::CFG_MAX_BATCH, 16'hFFC0);
        for (int i = 0; i < 4; i++) send_item(16'(10 * i), i == 3);

        // capacity lowered after loading: the earlier items no longer fit
        write_reg(gtp_pkg::CFG_MAX_BATCH, 16'd32);
        send_item(16'd900, 1'b0);
        send_item(16'd800, 1'b0);
        write_reg(gtp_pkg::CFG_CAPACITY, 16'd50);
        send_item(16'd20, 1'b1);

        // full store: the extra last item is dropped but the set still packs
        write_reg(gtp_pkg::CFG_CAPACITY, 16'd1);
        write_reg(gtp_pkg::CFG_MAX_BATCH, 16'd63);
        for (int i = 0; i < 33; i++) send_item(16'(i % 2), i == 32);

        // random sets with random settings
        while (sent < 200) begin
            if ($urandom_range(2) == 0) write_reg(gtp_pkg::CFG_CAPACITY, pick_cap());
            if ($urandom_range(2) == 0) write_reg(gtp_pkg::CFG_MAX_BATCH, pick_max());
            no_idle = (sent >= 100 && sent < 160);
            lim = ($urandom_range(9) == 0) ? 36 : 12;
            n = $urandom_range(1, lim);
            for (int i = 0; i < n; i++)
                send_item(pick_tokens(board.cap), (i == n - 1) || ($urandom_range(30) == 0));
        end

        start <= 1'b0;
        while (board.placements.size() > 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
